// ----- rtl/brtc_pkg.sv -----
// Shared types and constants for the binary real-time clock with alarm.
// Holds the register map, control bit positions and the command and result records.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package brtc_pkg;

	localparam int COUNT_WIDTH_DEF = 62;
	localparam int DT_WIDTH        = 62;
	localparam int ALARM_WIDTH     = 43;
	localparam int PRESC_WIDTH     = 26;
	localparam int MODE_WIDTH      = 4;
	localparam int CAL_WIDTH       = 8;
	localparam int CAL_DEPTH       = 8;
	localparam int CAL_IDX_W       = $clog2(CAL_DEPTH);
	localparam int WORD_W          = 10;
	localparam int DATA_W          = 32;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	localparam logic [WORD_W-1:0] W_CTRL      = 10'd0;
	localparam logic [WORD_W-1:0] W_MODE      = 10'd1;
	localparam logic [WORD_W-1:0] W_PRESC     = 10'd2;
	localparam logic [WORD_W-1:0] W_ALM_LO    = 10'd3;
	localparam logic [WORD_W-1:0] W_ALM_HI    = 10'd4;
	localparam logic [WORD_W-1:0] W_CMP_LO    = 10'd5;
	localparam logic [WORD_W-1:0] W_CMP_HI    = 10'd6;
	localparam logic [WORD_W-1:0] W_DT_LO     = 10'd8;
	localparam logic [WORD_W-1:0] W_DT_HI     = 10'd9;
	localparam logic [WORD_W-1:0] W_CAL_FIRST = 10'd12;
	localparam logic [WORD_W-1:0] W_CAL_LAST  = 10'd19;
	localparam logic [WORD_W-1:0] W_CNT_FIRST = 10'd20;
	localparam logic [WORD_W-1:0] W_CNT_LAST  = 10'd27;

	localparam int CTL_START     = 0;
	localparam int CTL_STOP      = 1;
	localparam int CTL_ALARM_ON  = 2;
	localparam int CTL_ALARM_OFF = 3;
	localparam int CTL_RESET     = 4;
	localparam int CTL_UPLOAD    = 5;
	localparam int CTL_DOWNLOAD  = 6;
	localparam int CTL_MATCH     = 7;
	localparam int CTL_WAKE_CLR  = 8;
	localparam int CTL_WAKE_SET  = 9;
	localparam int CTL_UPD_CLR   = 10;

	localparam int MODE_CALENDAR = 0;
	localparam int MODE_WAKE     = 1;
	localparam int MODE_PERIODIC = 2;
	localparam int MODE_KEEP_RUN = 3;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		SEL_CTRL,
		SEL_MODE,
		SEL_PRESC,
		SEL_ALM_LO,
		SEL_ALM_HI,
		SEL_CMP_LO,
		SEL_CMP_HI,
		SEL_DT_LO,
		SEL_DT_HI,
		SEL_CAL,
		SEL_CNT,
		SEL_UNMAPPED
	} sel_t;

	typedef struct packed {
		kind_t                kind;
		sel_t                 target;
		logic [CAL_IDX_W-1:0] cal_idx;
		logic [DATA_W-1:0]    data;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              wake_level;
		logic              match_level;
		logic              unmapped;
	} res_t;

endpackage

// ----- rtl/brtc_front.sv -----
// Front end of the clock: takes input transactions and classifies them.
// Turns the item kind and word index into a command record for the queue.
// Depends on brtc_pkg.
`timescale 1ns / 1ps

module brtc_front (
	input  logic [1:0]                    mode,
	input  logic [brtc_pkg::WORD_W-1:0]   word_index,
	input  logic [brtc_pkg::DATA_W-1:0]   write_data,
	output brtc_pkg::cmd_t                cmd
);

	brtc_pkg::sel_t target;

	always_comb begin
		unique case (word_index) inside
			brtc_pkg::W_CTRL:   target = brtc_pkg::SEL_CTRL;
			brtc_pkg::W_MODE:   target = brtc_pkg::SEL_MODE;
			brtc_pkg::W_PRESC:  target = brtc_pkg::SEL_PRESC;
			brtc_pkg::W_ALM_LO: target = brtc_pkg::SEL_ALM_LO;
			brtc_pkg::W_ALM_HI: target = brtc_pkg::SEL_ALM_HI;
			brtc_pkg::W_CMP_LO: target = brtc_pkg::SEL_CMP_LO;
			brtc_pkg::W_CMP_HI: target = brtc_pkg::SEL_CMP_HI;
			brtc_pkg::W_DT_LO:  target = brtc_pkg::SEL_DT_LO;
			brtc_pkg::W_DT_HI:  target = brtc_pkg::SEL_DT_HI;
			[brtc_pkg::W_CAL_FIRST:brtc_pkg::W_CAL_LAST]: target = brtc_pkg::SEL_CAL;
			[brtc_pkg::W_CNT_FIRST:brtc_pkg::W_CNT_LAST]: target = brtc_pkg::SEL_CNT;
			default:            target = brtc_pkg::SEL_UNMAPPED;
		endcase
	end

	always_comb begin
		cmd.kind    = brtc_pkg::kind_t'(mode);
		cmd.target  = target;
		cmd.cal_idx = brtc_pkg::CAL_IDX_W'(word_index - brtc_pkg::W_CAL_FIRST);
		cmd.data    = write_data;
	end

endmodule

// ----- rtl/brtc_queue.sv -----
// Short command queue between the front end and the execution back end.
// Lets either side stall on its own; holds classified command records.
// Depends on brtc_pkg.
`timescale 1ns / 1ps

module brtc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  brtc_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output brtc_pkg::cmd_t pop_cmd
);

	brtc_pkg::cmd_t                entry_q [brtc_pkg::QUEUE_DEPTH];
	logic [brtc_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [brtc_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [brtc_pkg::QPTR_W:0]     count_q;
	logic                          push;
	logic                          pop;

	assign push_ready = count_q != (brtc_pkg::QPTR_W+1)'(brtc_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/brtc_back.sv -----
// Execution back end of the clock: holds the counter, registers and alarm logic.
// Carries out one queued command per cycle while its registered result stage has room.
// Depends on brtc_pkg.
`timescale 1ns / 1ps

module brtc_back #(
	parameter int COUNT_WIDTH = brtc_pkg::COUNT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  brtc_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output brtc_pkg::res_t res
);

	localparam int DT = brtc_pkg::DT_WIDTH;

	logic [COUNT_WIDTH-1:0]              cnt_q;
	logic [COUNT_WIDTH-1:0]              latch_q;
	logic                                latch_vld_q;
	logic                                running_q;
	logic                                armed_q;
	logic                                wake_q;
	logic                                match_q;
	logic                                upd_q;
	logic [brtc_pkg::MODE_WIDTH-1:0]     mode_q;
	logic [brtc_pkg::PRESC_WIDTH-1:0]    presc_q;
	logic [brtc_pkg::ALARM_WIDTH-1:0]    alarm_q;
	logic [DT-1:0]                       cmp_q;
	logic [DT-1:0]                       stage_q;
	logic [brtc_pkg::CAL_WIDTH-1:0]      cal_q [brtc_pkg::CAL_DEPTH];
	logic                                res_valid_q;
	brtc_pkg::res_t                      res_q;

	logic [COUNT_WIDTH-1:0]              n_cnt;
	logic [COUNT_WIDTH-1:0]              n_latch;
	logic                                n_latch_vld;
	logic                                n_running;
	logic                                n_armed;
	logic                                n_wake;
	logic                                n_match;
	logic                                n_upd;
	logic [brtc_pkg::MODE_WIDTH-1:0]     n_mode;
	logic [brtc_pkg::PRESC_WIDTH-1:0]    n_presc;
	logic [brtc_pkg::ALARM_WIDTH-1:0]    n_alarm;
	logic [DT-1:0]                       n_cmp;
	logic [DT-1:0]                       n_stage;
	logic                                cal_we;
	logic [brtc_pkg::DATA_W-1:0]         rd;
	logic                                miss;
	logic                                fire;
	logic                                exec;

	assign cmd_ready = !res_valid_q || res_ready;
	assign exec      = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		logic [DT-1:0]                 hi_src;
		logic [brtc_pkg::DATA_W-1:0]   v;
		hi_src      = DT'(latch_vld_q ? latch_q : cnt_q);
		v           = cmd.data;
		n_cnt       = cnt_q;
		n_latch     = latch_q;
		n_latch_vld = latch_vld_q;
		n_running   = running_q;
		n_armed     = armed_q;
		n_wake      = wake_q;
		n_match     = match_q;
		n_upd       = upd_q;
		n_mode      = mode_q;
		n_presc     = presc_q;
		n_alarm     = alarm_q;
		n_cmp       = cmp_q;
		n_stage     = stage_q;
		cal_we      = 1'b0;
		rd          = '0;
		miss        = 1'b0;
		unique case (cmd.kind)
			brtc_pkg::KIND_TICK: begin
				if (running_q) begin
					n_cnt = cnt_q + 1'b1;
				end
			end
			brtc_pkg::KIND_READ: begin
				unique case (cmd.target)
					brtc_pkg::SEL_CTRL: begin
						rd[brtc_pkg::CTL_START]    = running_q;
						rd[brtc_pkg::CTL_ALARM_ON] = armed_q;
						rd[brtc_pkg::CTL_MATCH]    = match_q;
						rd[brtc_pkg::CTL_UPD_CLR]  = upd_q;
					end
					brtc_pkg::SEL_MODE:   rd = brtc_pkg::DATA_W'(mode_q);
					brtc_pkg::SEL_PRESC:  rd = brtc_pkg::DATA_W'(presc_q);
					brtc_pkg::SEL_ALM_LO: rd = alarm_q[31:0];
					brtc_pkg::SEL_ALM_HI: rd = brtc_pkg::DATA_W'(alarm_q[brtc_pkg::ALARM_WIDTH-1:32]);
					brtc_pkg::SEL_CMP_LO: rd = cmp_q[31:0];
					brtc_pkg::SEL_CMP_HI: rd = brtc_pkg::DATA_W'(cmp_q[DT-1:32]);
					brtc_pkg::SEL_DT_LO: begin
						n_latch     = cnt_q;
						n_latch_vld = 1'b1;
						rd          = cnt_q[31:0];
					end
					brtc_pkg::SEL_DT_HI: begin
						n_latch_vld = 1'b0;
						rd          = brtc_pkg::DATA_W'(hi_src[DT-1:32]);
					end
					brtc_pkg::SEL_CAL:    rd = brtc_pkg::DATA_W'(cal_q[cmd.cal_idx]);
					brtc_pkg::SEL_CNT:    rd = '0;
					default:              miss = 1'b1;
				endcase
			end
			brtc_pkg::KIND_WRITE: begin
				unique case (cmd.target)
					brtc_pkg::SEL_CTRL: begin
						if (v[brtc_pkg::CTL_UPD_CLR]) begin
							n_upd = 1'b0;
						end
						if (v[brtc_pkg::CTL_RESET]) begin
							n_cnt = '0;
							n_upd = 1'b1;
						end
						if (v[brtc_pkg::CTL_UPLOAD]) begin
							n_cnt = stage_q[COUNT_WIDTH-1:0];
							n_upd = 1'b1;
						end
						if (v[brtc_pkg::CTL_DOWNLOAD]) begin
							n_stage = DT'(n_cnt);
						end
						if (v[brtc_pkg::CTL_START]) begin
							n_running = 1'b1;
						end
						if (v[brtc_pkg::CTL_STOP]) begin
							n_running = 1'b0;
						end
						if (v[brtc_pkg::CTL_ALARM_OFF]) begin
							n_armed = 1'b0;
							n_wake  = 1'b0;
							n_match = 1'b0;
						end else if (v[brtc_pkg::CTL_ALARM_ON]) begin
							n_armed = 1'b1;
						end
						if (v[brtc_pkg::CTL_WAKE_CLR]) begin
							n_wake  = 1'b0;
							n_match = 1'b0;
						end
						if (v[brtc_pkg::CTL_WAKE_SET]) begin
							n_wake = 1'b1;
						end
					end
					brtc_pkg::SEL_MODE:   n_mode  = v[brtc_pkg::MODE_WIDTH-1:0];
					brtc_pkg::SEL_PRESC:  n_presc = v[brtc_pkg::PRESC_WIDTH-1:0];
					brtc_pkg::SEL_ALM_LO: n_alarm[31:0] = v;
					brtc_pkg::SEL_ALM_HI:
						n_alarm[brtc_pkg::ALARM_WIDTH-1:32] = v[brtc_pkg::ALARM_WIDTH-33:0];
					brtc_pkg::SEL_CMP_LO: n_cmp[31:0] = v;
					brtc_pkg::SEL_CMP_HI: n_cmp[DT-1:32] = v[DT-33:0];
					brtc_pkg::SEL_DT_LO:  n_stage[31:0] = v;
					brtc_pkg::SEL_DT_HI:  n_stage[DT-1:32] = v[DT-33:0];
					brtc_pkg::SEL_CAL:    cal_we = 1'b1;
					brtc_pkg::SEL_CNT:    miss = 1'b0;
					default:              miss = 1'b1;
				endcase
			end
			default: begin
				rd = '0;
			end
		endcase

		fire = n_armed && n_running && !n_mode[brtc_pkg::MODE_CALENDAR] && (&n_cmp)
			&& (DT'(n_alarm) <= DT'(n_cnt));
		if (fire) begin
			n_armed = n_mode[brtc_pkg::MODE_PERIODIC];
			n_match = 1'b1;
			if (n_mode[brtc_pkg::MODE_WAKE]) begin
				n_wake = 1'b1;
			end
			if (n_mode[brtc_pkg::MODE_PERIODIC]) begin
				n_cnt = '0;
			end
			if (!n_mode[brtc_pkg::MODE_KEEP_RUN]) begin
				n_running = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			latch_q     <= '0;
			latch_vld_q <= 1'b0;
			running_q   <= 1'b0;
			armed_q     <= 1'b0;
			wake_q      <= 1'b0;
			match_q     <= 1'b0;
			upd_q       <= 1'b0;
			mode_q      <= '0;
			presc_q     <= '0;
			alarm_q     <= '0;
			cmp_q       <= '0;
			stage_q     <= '0;
			for (int i = 0; i < brtc_pkg::CAL_DEPTH; i++) begin
				cal_q[i] <= '0;
			end
			res_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				cnt_q       <= n_cnt;
				latch_q     <= n_latch;
				latch_vld_q <= n_latch_vld;
				running_q   <= n_running;
				armed_q     <= n_armed;
				wake_q      <= n_wake;
				match_q     <= n_match;
				upd_q       <= n_upd;
				mode_q      <= n_mode;
				presc_q     <= n_presc;
				alarm_q     <= n_alarm;
				cmp_q       <= n_cmp;
				stage_q     <= n_stage;
				if (cal_we) begin
					cal_q[cmd.cal_idx] <= cmd.data[brtc_pkg::CAL_WIDTH-1:0];
				end
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q.read_data   <= rd;
			res_q.wake_level  <= n_wake;
			res_q.match_level <= n_match;
			res_q.unmapped    <= miss;
		end
	end

	a_match_needs_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(match_q) |-> $past(exec))
		else $error("match flag rose without an executed transaction");

	a_count_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(cnt_q))
		else $error("counter changed without an executed transaction");

	a_latch_needs_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(latch_vld_q) |-> $past(exec))
		else $error("datetime latch set without an executed transaction");

	a_result_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> res_valid_q && res_q.match_level == match_q && res_q.wake_level == wake_q)
		else $error("result register does not reflect the executed transaction");

endmodule

// ----- rtl/binary_rtc_with_alarm_core.sv -----
// Top level of the binary real-time clock with alarm.
// Joins the classifying front end, the command queue and the execution back end.
// Depends on brtc_pkg, brtc_front, brtc_queue and brtc_back.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries one item per transaction: tuser selects a one-second
// tick, a register read, a register write or an empty item, and tdata carries the word index
// and the write data. The master stream returns exactly one result transaction
// per item, in order, with the read data and both interrupt levels in tdata and
// the unmapped-access flag in tuser.
// An item accepted into the command queue is executed once it reaches the queue head and
// the result register is free; its result is then presented from the output register. One item is
// taken per cycle while the queue has room; the back end executes one command per cycle while
// its result register can take it, with the counter increment and alarm compare done in that same cycle.
// A two-entry command queue sits between the front end and the back end, and
// the result sits in an output register. When the receiver stalls, the result
// holds, the queue fills and tready drops once it is full.
// Reset clears the counter, all flags and the programmable registers (not the result data or queue entries)
// to zero at once; there is no clearing sequence, and items are taken from the first cycle after reset.

module binary_rtc_with_alarm_core #(
	parameter int COUNT_WIDTH = brtc_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // word_index[9:0], write_data[41:10], zero fill
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // read_data[31:0], wake_level[32], match_level[33], zero fill
	output logic [0:0]  m_axis_tuser   // unmapped[0]
);

	brtc_pkg::cmd_t front_cmd;
	brtc_pkg::cmd_t head_cmd;
	brtc_pkg::res_t res;
	logic           head_valid;
	logic           head_ready;

	brtc_front u_front (
		.mode       (s_axis_tuser),
		.word_index (s_axis_tdata[9:0]),
		.write_data (s_axis_tdata[41:10]),
		.cmd        (front_cmd)
	);

	brtc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_axis_tvalid),
		.push_ready (s_axis_tready),
		.push_cmd   (front_cmd),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_cmd    (head_cmd)
	);

	brtc_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (head_valid),
		.cmd_ready  (head_ready),
		.cmd        (head_cmd),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	assign m_axis_tdata = {6'b0, res.match_level, res.wake_level, res.read_data};
	assign m_axis_tuser = res.unmapped;

endmodule

// ----- tb/tb_binary_rtc_with_alarm_core.sv -----
// Self-checking testbench for binary_rtc_with_alarm_core: a directed table and then random
// tick, register read, register write and empty transactions, each result compared with a table entry or a predictor.
// Depends on brtc_pkg and binary_rtc_with_alarm_core.
`timescale 1ns / 1ps

module tb_binary_rtc_with_alarm_core;

	localparam int          CNT_W       = brtc_pkg::COUNT_WIDTH_DEF;
	localparam logic [61:0] COUNT_MASK  = {62{1'b1}} >> (62 - CNT_W);
	localparam int          ITEM_TARGET = 1350;
	localparam int          HOLD_AT     = 300;
	localparam int          HOLD_CYCLES = 300;
	localparam int          DRAIN       = 20;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          N_ROWS      = 26;

	typedef struct {
		brtc_pkg::kind_t kind;
		logic [9:0]      word;
		logic [31:0]     data;
		bit              typed;
		logic [31:0]     rd;
		bit              wk;
		bit              mt;
		bit              um;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	// Predicted state of the clock.
	logic [61:0] sec_count   = '0;
	logic [61:0] latched     = '0;
	logic [61:0] staging     = '0;
	logic [61:0] cmp_bits    = '0;
	logic [42:0] alarm_tgt   = '0;
	logic [25:0] presc       = '0;
	logic [3:0]  mode_reg    = '0;
	logic [7:0]  cal_mem [8] = '{default: '0};
	bit          rtc_running = 0;
	bit          alarm_armed = 0;
	bit          wake_flag   = 0;
	bit          match_flag  = 0;
	bit          upd_flag    = 0;
	bit          latch_ok    = 0;

	brtc_pkg::res_t pending_results [$];
	int   items_sent    = 0;
	int   results_seen  = 0;
	int   errors        = 0;
	int   alarm_hits    = 0;
	int   kind_count [4] = '{default: 0};
	int   cycles        = 0;
	bit   hold_rx       = 0;
	bit   tx_calm       = 0;

	step_row_t directed_rows [N_ROWS] = '{
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_CTRL,      32'h0,        1, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_DT_HI,     32'h0,        1, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  10'd7,                 32'h0,        1, 32'h0,        0, 0, 1},
		'{brtc_pkg::KIND_WRITE, 10'd1023,              32'hffffffff, 1, 32'h0,        0, 0, 1},
		'{brtc_pkg::KIND_NONE,  10'd1023,              32'hffffffff, 1, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_CNT_LAST,  32'h0,        1, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_CNT_FIRST, 32'hffffffff, 1, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_CAL_LAST,  32'hffffffff, 1, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_CAL_LAST,  32'h0,        1, 32'h000000ff, 0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_PRESC,     32'hffffffff, 1, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_PRESC,     32'h0,        1, 32'h03ffffff, 0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_MODE,      32'hffffffff, 1, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_MODE,      32'h0,        1, 32'h0000000f, 0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_MODE,
			32'(1 << brtc_pkg::MODE_WAKE), 0, 32'h0, 0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_CMP_LO,    32'hffffffff, 0, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_CMP_HI,    32'hffffffff, 0, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_CMP_HI,    32'h0,        1, 32'h3fffffff, 0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_DT_LO,     32'hffffffff, 0, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_DT_HI,     32'hffffffff, 0, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_CTRL,
			32'((1 << brtc_pkg::CTL_UPLOAD) | (1 << brtc_pkg::CTL_START) |
			(1 << brtc_pkg::CTL_ALARM_ON)), 0, 32'h0, 0, 0, 0},
		'{brtc_pkg::KIND_TICK,  10'd1023,              32'hffffffff, 0, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_CTRL,      32'hffffffff, 0, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_WRITE, brtc_pkg::W_CTRL,
			32'((1 << brtc_pkg::CTL_UPLOAD) | (1 << brtc_pkg::CTL_START)), 0, 32'h0, 0, 0, 0},
		'{brtc_pkg::KIND_TICK,  10'd0,                 32'h0,        0, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_DT_LO,     32'h0,        0, 32'h0,        0, 0, 0},
		'{brtc_pkg::KIND_READ,  brtc_pkg::W_DT_HI,     32'h0,        0, 32'h0,        0, 0, 0}
	};

	binary_rtc_with_alarm_core #(
		.COUNT_WIDTH(CNT_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one item to the predicted state and returns the result it should produce.
	function automatic brtc_pkg::res_t rtc_predict(input brtc_pkg::kind_t k,
		input logic [9:0] w, input logic [31:0] d);
		brtc_pkg::res_t r;
		logic [61:0]    snap;
		r = '0;
		case (k)
		brtc_pkg::KIND_TICK: begin
			if (rtc_running)
				sec_count = (sec_count + 62'd1) & COUNT_MASK;
		end
		brtc_pkg::KIND_READ: begin
			case (w)
			brtc_pkg::W_CTRL:   r.read_data = 32'(rtc_running) |
				(32'(alarm_armed) << brtc_pkg::CTL_ALARM_ON) |
				(32'(match_flag) << brtc_pkg::CTL_MATCH) |
				(32'(upd_flag) << brtc_pkg::CTL_UPD_CLR);
			brtc_pkg::W_MODE:   r.read_data = 32'(mode_reg);
			brtc_pkg::W_PRESC:  r.read_data = 32'(presc);
			brtc_pkg::W_ALM_LO: r.read_data = alarm_tgt[31:0];
			brtc_pkg::W_ALM_HI: r.read_data = 32'(alarm_tgt[42:32]);
			brtc_pkg::W_CMP_LO: r.read_data = cmp_bits[31:0];
			brtc_pkg::W_CMP_HI: r.read_data = 32'(cmp_bits[61:32]);
			brtc_pkg::W_DT_LO: begin
				latched = sec_count & COUNT_MASK;
				latch_ok = 1;
				r.read_data = latched[31:0];
			end
			brtc_pkg::W_DT_HI: begin
				snap = latch_ok ? latched : sec_count;
				latch_ok = 0;
				r.read_data = 32'(snap[61:32]);
			end
			default: begin
				if (w >= brtc_pkg::W_CAL_FIRST && w <= brtc_pkg::W_CAL_LAST)
					r.read_data = 32'(cal_mem[3'(w - brtc_pkg::W_CAL_FIRST)]);
				else if (!(w >= brtc_pkg::W_CNT_FIRST && w <= brtc_pkg::W_CNT_LAST))
					r.unmapped = 1'b1;
			end
			endcase
		end
		brtc_pkg::KIND_WRITE: begin
			case (w)
			brtc_pkg::W_CTRL: begin
				if (d[brtc_pkg::CTL_UPD_CLR])
					upd_flag = 0;
				if (d[brtc_pkg::CTL_RESET]) begin
					sec_count = '0;
					upd_flag = 1;
				end
				if (d[brtc_pkg::CTL_UPLOAD]) begin
					sec_count = staging & COUNT_MASK;
					upd_flag = 1;
				end
				if (d[brtc_pkg::CTL_DOWNLOAD])
					staging = sec_count;
				if (d[brtc_pkg::CTL_START])
					rtc_running = 1;
				if (d[brtc_pkg::CTL_STOP])
					rtc_running = 0;
				if (d[brtc_pkg::CTL_ALARM_OFF]) begin
					alarm_armed = 0;
					wake_flag = 0;
					match_flag = 0;
				end else if (d[brtc_pkg::CTL_ALARM_ON]) begin
					alarm_armed = 1;
				end
				if (d[brtc_pkg::CTL_WAKE_CLR]) begin
					wake_flag = 0;
					match_flag = 0;
				end
				if (d[brtc_pkg::CTL_WAKE_SET])
					wake_flag = 1;
			end
			brtc_pkg::W_MODE:   mode_reg = d[3:0];
			brtc_pkg::W_PRESC:  presc = d[25:0];
			brtc_pkg::W_ALM_LO: alarm_tgt[31:0] = d;
			brtc_pkg::W_ALM_HI: alarm_tgt[42:32] = d[10:0];
			brtc_pkg::W_CMP_LO: cmp_bits[31:0] = d;
			brtc_pkg::W_CMP_HI: cmp_bits[61:32] = d[29:0];
			brtc_pkg::W_DT_LO:  staging[31:0] = d;
			brtc_pkg::W_DT_HI:  staging[61:32] = d[29:0];
			default: begin
				if (w >= brtc_pkg::W_CAL_FIRST && w <= brtc_pkg::W_CAL_LAST)
					cal_mem[3'(w - brtc_pkg::W_CAL_FIRST)] = d[7:0];
				else if (!(w >= brtc_pkg::W_CNT_FIRST && w <= brtc_pkg::W_CNT_LAST))
					r.unmapped = 1'b1;
			end
			endcase
		end
		default: ;
		endcase

		if (alarm_armed && rtc_running && !mode_reg[brtc_pkg::MODE_CALENDAR] &&
			cmp_bits == '1 && 62'(alarm_tgt) <= sec_count) begin
			alarm_armed = mode_reg[brtc_pkg::MODE_PERIODIC];
			match_flag = 1;
			if (mode_reg[brtc_pkg::MODE_WAKE])
				wake_flag = 1;
			if (mode_reg[brtc_pkg::MODE_PERIODIC])
				sec_count = '0;
			if (!mode_reg[brtc_pkg::MODE_KEEP_RUN])
				rtc_running = 0;
			alarm_hits++;
		end
		r.wake_level = wake_flag;
		r.match_level = match_flag;
		return r;
	endfunction

	// Offers one item and waits for its transaction; the expectation is queued on acceptance.
	task automatic send_item(input brtc_pkg::kind_t k, input logic [9:0] w,
		input logic [31:0] d, input bit typed = 0, input brtc_pkg::res_t want = '0);
		int             gap;
		brtc_pkg::res_t r;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, d, w};
		s_axis_tuser <= k;
		do @(posedge clk); while (!s_axis_tready);
		r = rtc_predict(k, w, d);
		pending_results.push_back(typed ? want : r);
		items_sent++;
		kind_count[k]++;
	endtask

	function automatic logic [9:0] pick_word();
		return ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) :
			10'($urandom_range(0, 31));
	endfunction

	// Programs an alarm, starts the clock and sends ticks and other items that may run into the match.
	task automatic alarm_run();
		logic [31:0] m;
		int          n;
		int          pick;
		m = $urandom_range(0, 15);
		if ($urandom_range(0, 3) != 0)
			m[brtc_pkg::MODE_CALENDAR] = 1'b0;
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_MODE, m);
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_CMP_LO,
			($urandom_range(0, 7) == 0) ? $urandom : 32'hffffffff);
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_CMP_HI,
			($urandom_range(0, 7) == 0) ? $urandom : 32'hffffffff);
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_ALM_LO, $urandom_range(0, 12));
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_ALM_HI,
			($urandom_range(0, 5) == 0) ? $urandom : 32'h0);
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_CTRL,
			32'((1 << brtc_pkg::CTL_START) | (1 << brtc_pkg::CTL_ALARM_ON) |
			($urandom_range(0, 1) << brtc_pkg::CTL_RESET) |
			($urandom_range(0, 1) << brtc_pkg::CTL_WAKE_CLR)));
		n = $urandom_range(3, 20);
		repeat (n) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				send_item(brtc_pkg::KIND_TICK, pick_word(), $urandom);
			else if (pick == 6)
				send_item(brtc_pkg::KIND_READ, brtc_pkg::W_CTRL, $urandom);
			else if (pick == 7)
				send_item(brtc_pkg::KIND_READ,
					$urandom_range(0, 1) ? brtc_pkg::W_DT_LO : brtc_pkg::W_DT_HI, $urandom);
			else if (pick == 8)
				send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_CTRL,
					32'(1) << $urandom_range(0, 10));
			else
				send_item(brtc_pkg::KIND_READ, pick_word(), $urandom);
		end
	endtask

	// Loads the counter from staging, often near the top so it may wrap, ticks, downloads and reads it.
	task automatic staging_run();
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_DT_LO,
			$urandom_range(0, 1) ? 32'hffffffff - $urandom_range(0, 5) : $urandom);
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_DT_HI,
			$urandom_range(0, 1) ? 32'hffffffff : $urandom);
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_CTRL,
			32'((1 << brtc_pkg::CTL_UPLOAD) | (1 << brtc_pkg::CTL_START)));
		repeat ($urandom_range(1, 8))
			send_item(brtc_pkg::KIND_TICK, pick_word(), $urandom);
		send_item(brtc_pkg::KIND_WRITE, brtc_pkg::W_CTRL, 32'(1 << brtc_pkg::CTL_DOWNLOAD));
		if ($urandom_range(0, 1))
			send_item(brtc_pkg::KIND_READ, brtc_pkg::W_DT_LO, $urandom);
		send_item(brtc_pkg::KIND_READ, brtc_pkg::W_DT_HI, $urandom);
	endtask

	task automatic noise_run();
		repeat ($urandom_range(4, 16))
			send_item(brtc_pkg::kind_t'($urandom_range(0, 3)), pick_word(), $urandom);
	endtask

	initial begin : main_seq
		int             pick;
		brtc_pkg::res_t want;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			want.read_data = directed_rows[i].rd;
			want.wake_level = directed_rows[i].wk;
			want.match_level = directed_rows[i].mt;
			want.unmapped = directed_rows[i].um;
			send_item(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].data,
				directed_rows[i].typed, want);
		end

		while (items_sent < ITEM_TARGET) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 9)
				alarm_run();
			else if (pick < 14)
				staging_run();
			else
				noise_run();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Covered %0d items: %0d ticks, %0d reads, %0d writes, %0d empty.",
			items_sent, kind_count[brtc_pkg::KIND_TICK], kind_count[brtc_pkg::KIND_READ],
			kind_count[brtc_pkg::KIND_WRITE], kind_count[brtc_pkg::KIND_NONE]);
		$display("Checked %0d results, %0d alarm matches, %0d errors.",
			results_seen, alarm_hits, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// The receiver holds off once for a long stretch so that the queue fills and tready drops.
	initial begin : rx_hold
		wait (items_sent >= HOLD_AT);
		hold_rx = 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx = 0;
	end

	initial begin : result_check
		int             gap;
		int             calm_left;
		brtc_pkg::res_t want;
		bit             bad;
		calm_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 5) == 0)
				calm_left = $urandom_range(20, 60);
			gap = (calm_left > 0) ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			while (hold_rx) begin
				m_axis_tready <= 1'b0;
				@(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);

			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result transaction %0d: data %h user %b",
						results_seen, m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_results.pop_front();
				bad = (m_axis_tdata[31:0] !== want.read_data) ||
					(m_axis_tdata[32] !== want.wake_level) ||
					(m_axis_tdata[33] !== want.match_level) ||
					(m_axis_tuser[0] !== want.unmapped);
				if (bad) begin
					errors++;
					if (errors <= 10)
						$display({"Mismatch on result %0d: read_data %h/%h, wakeup %b/%b, ",
							"match %b/%b, unmapped %b/%b (expected/actual)"}, results_seen,
							want.read_data, m_axis_tdata[31:0], want.wake_level,
							m_axis_tdata[32], want.match_level, m_axis_tdata[33],
							want.unmapped, m_axis_tuser[0]);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.",
			cycles, pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- binary_rtc_with_alarm_core.f -----
rtl/brtc_pkg.sv
rtl/brtc_front.sv
rtl/brtc_queue.sv
rtl/brtc_back.sv
rtl/binary_rtc_with_alarm_core.sv
tb/tb_binary_rtc_with_alarm_core.sv
